// ===== sv/fasid_pkg.sv =====
// fasid_pkg: shared types, codes and constants for the sorted array store
// payload structs for the request and response transfers, cell control types
// no dependencies
package fasid_pkg;

    localparam int DATA_W        = 32;
    localparam int FUNC_W        = 3;
    localparam int IDX_W         = 5;
    localparam int STAT_W        = 2;
    localparam int DEPTH_DEFAULT = 16;

    // operation codes carried in func
    localparam logic [FUNC_W-1:0] FUNC_SORTED_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_OVERWRITE     = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_INSERT_AT     = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DELETE_FIRST  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DELETE_ALL    = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_READ          = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_BAD_INDEX = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0]         index;
    } req_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [IDX_W-1:0]         position;
        logic [IDX_W-1:0]         removed;
        logic [IDX_W-1:0]         fill;
        logic signed [DATA_W-1:0] read_value;
    } rsp_item_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_DELETE
    } cell_op_t;

    typedef struct packed {
        logic                     eval;
        cell_op_t                 op;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

    typedef struct packed {
        logic ge;
        logic eq;
    } cell_flags_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_APPLY
    } state_t;

endpackage

// ===== sv/fasid_cell.sv =====
// fasid_cell: one storage slot of the sorted array chain
// holds a word, registers compare flags and takes data from either neighbor
// depends on fasid_pkg
module fasid_cell
    import fasid_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int CW   = $clog2(DEPTH + 1)
)
(
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic [CW-1:0]            pos,
    input  logic [CW-1:0]            count,
    input  logic signed [DATA_W-1:0] left,
    input  logic signed [DATA_W-1:0] right,
    output logic signed [DATA_W-1:0] data,
    output cell_flags_t              flags
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    cell_flags_t              flags_reg;
    logic                     valid;
    logic                     at_pos;
    logic                     above_pos;

    assign valid     = MY_IDX < count;
    assign at_pos    = MY_IDX == pos;
    assign above_pos = MY_IDX > pos;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_WRITE:
            begin
                if (at_pos)
                begin
                    data_next = ctrl.value;
                end
            end
            CELL_INSERT:
            begin
                if (at_pos)
                begin
                    data_next = ctrl.value;
                end
                else if (above_pos)
                begin
                    data_next = left;
                end
            end
            CELL_DELETE:
            begin
                if (at_pos || above_pos)
                begin
                    data_next = right;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (ctrl.eval)
        begin
            flags_reg.ge <= valid && (data_reg >= ctrl.value);
            flags_reg.eq <= valid && (data_reg == ctrl.value);
        end
    end

    assign data  = data_reg;
    assign flags = flags_reg;

endmodule

// ===== sv/fasid_locate.sv =====
// fasid_locate: finds the first cell whose flag is set
// log-depth prefix or across the chain, then a one-hot to binary encode
// depends on fasid_pkg
module fasid_locate
    import fasid_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int CW   = $clog2(DEPTH + 1)
)
(
    input  logic [DEPTH-1:0] hits,
    output logic             any,
    output logic [CW-1:0]    pos
);

    logic [DEPTH-1:0] pre;
    logic [DEPTH-1:0] first;

    always_comb
    begin
        pre = hits;
        for (int s = 1; s < DEPTH; s = s * 2)
        begin
            pre = pre | (pre << s);
        end
        // a hit with no hit below it
        first = hits & ~(pre << 1);
        pos   = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (first[i])
            begin
                pos = pos | CW'(i);
            end
        end
    end

    assign any = |hits;

endmodule

// ===== sv/fixed_array_sorted_insert_delete.sv =====
// sorted array store: each request passes the compare and apply states; the response
// is registered on leaving apply, which waits while the response slot is stalled;
// no new request is taken until idle. delete-all removes one match per compare and
// shift pass through the cell chain. reset (rst_n, async low) empties the store
// and clears response valid; entry contents are not cleared, only the fill count.
// depends on fasid_pkg, fasid_cell, fasid_locate
module fixed_array_sorted_insert_delete
    import fasid_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    state_t                   state_reg;
    state_t                   state_next;
    req_item_t                op_reg;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic [CW-1:0]            removed_reg;
    logic [CW-1:0]            removed_next;
    rsp_item_t                rsp_reg;
    rsp_item_t                rsp_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;

    cell_ctrl_t               cell_ctrl;
    logic [CW-1:0]            cell_pos;
    logic signed [DATA_W-1:0] cell_data [DEPTH];
    cell_flags_t              cell_flags [DEPTH];
    logic [DEPTH-1:0]         ge_vec;
    logic [DEPTH-1:0]         eq_vec;
    logic [DEPTH-1:0]         hit_vec;
    logic                     loc_any;
    logic [CW-1:0]            loc_pos;

    logic [XW-1:0]            idx_x;
    logic [XW-1:0]            cnt_x;
    logic [AW-1:0]            rd_sel;
    logic                     slot_free;
    logic                     again;
    logic                     done;

    assign req_stall = (state_reg != ST_IDLE);
    assign idx_x     = XW'(op_reg.index);
    assign cnt_x     = XW'(count_reg);
    assign rd_sel    = AW'(op_reg.index);
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign hit_vec   = (op_reg.func == FUNC_SORTED_INSERT) ? ge_vec : eq_vec;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic signed [DATA_W-1:0] left_data;
            logic signed [DATA_W-1:0] right_data;

            if (g == 0)
            begin : g_first
                assign left_data = op_reg.value;
            end
            else
            begin : g_mid_l
                assign left_data = cell_data[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign right_data = cell_data[g];
            end
            else
            begin : g_mid_r
                assign right_data = cell_data[g+1];
            end

            fasid_cell #(
                .IDX   (g),
                .DEPTH (DEPTH)
            ) u_cell (
                .clk   (clk),
                .ctrl  (cell_ctrl),
                .pos   (cell_pos),
                .count (count_reg),
                .left  (left_data),
                .right (right_data),
                .data  (cell_data[g]),
                .flags (cell_flags[g])
            );

            assign ge_vec[g] = cell_flags[g].ge;
            assign eq_vec[g] = cell_flags[g].eq;
        end
    endgenerate

    fasid_locate #(
        .DEPTH (DEPTH)
    ) u_locate (
        .hits (hit_vec),
        .any  (loc_any),
        .pos  (loc_pos)
    );

    always_comb
    begin
        cell_op_t                 act_op;
        logic [CW-1:0]            act_pos;
        logic [CW-1:0]            act_count;
        logic [STAT_W-1:0]        act_status;
        logic [IDX_W-1:0]         act_position;
        logic [IDX_W-1:0]         act_removed;
        logic signed [DATA_W-1:0] act_rd;

        state_next     = state_reg;
        count_next     = count_reg;
        removed_next   = removed_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cell_ctrl.eval  = 1'b0;
        cell_ctrl.op    = CELL_HOLD;
        cell_ctrl.value = op_reg.value;
        again          = 1'b0;
        done           = 1'b0;

        act_op       = CELL_HOLD;
        act_pos      = loc_pos;
        act_count    = count_reg;
        act_status   = STATUS_OK;
        act_position = '0;
        act_removed  = '0;
        act_rd       = '0;

        case (op_reg.func)
            FUNC_SORTED_INSERT:
            begin
                act_pos = loc_any ? loc_pos : count_reg;
                // larger than everything in a full store: it falls off the end
                if (loc_any || count_reg != FULL)
                begin
                    act_op    = CELL_INSERT;
                    act_count = (count_reg == FULL) ? count_reg : count_reg + 1'b1;
                end
                act_position = IDX_W'(act_pos);
            end
            FUNC_OVERWRITE:
            begin
                if (idx_x < cnt_x)
                begin
                    act_op       = CELL_WRITE;
                    act_pos      = CW'(idx_x);
                    act_position = op_reg.index;
                end
                else
                begin
                    act_status = STATUS_BAD_INDEX;
                end
            end
            FUNC_INSERT_AT:
            begin
                if (idx_x <= cnt_x && idx_x < XW'(DEPTH))
                begin
                    act_op       = CELL_INSERT;
                    act_pos      = CW'(idx_x);
                    act_count    = (count_reg == FULL) ? count_reg : count_reg + 1'b1;
                    act_position = op_reg.index;
                end
                else
                begin
                    act_status = STATUS_BAD_INDEX;
                end
            end
            FUNC_DELETE_FIRST:
            begin
                if (loc_any)
                begin
                    act_op       = CELL_DELETE;
                    act_count    = count_reg - 1'b1;
                    act_position = IDX_W'(loc_pos);
                    act_removed  = IDX_W'(1);
                end
                else
                begin
                    act_status = STATUS_NOT_FOUND;
                end
            end
            FUNC_DELETE_ALL:
            begin
                if (loc_any)
                begin
                    act_op    = CELL_DELETE;
                    act_count = count_reg - 1'b1;
                    again     = 1'b1;
                end
                else
                begin
                    act_status  = (removed_reg == '0) ? STATUS_NOT_FOUND : STATUS_OK;
                    act_removed = IDX_W'(removed_reg);
                end
            end
            FUNC_READ:
            begin
                if (idx_x < cnt_x)
                begin
                    act_rd       = cell_data[rd_sel];
                    act_position = op_reg.index;
                end
                else
                begin
                    act_status = STATUS_BAD_INDEX;
                end
            end
            default:
            begin
                act_status = STATUS_BAD_INDEX;
            end
        endcase

        case (state_reg)
            ST_IDLE:
            begin
                removed_next = '0;
                if (req_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cell_ctrl.eval = 1'b1;
                state_next     = ST_APPLY;
            end
            ST_APPLY:
            begin
                cell_pos = act_pos;
                if (again)
                begin
                    // one match gone, compare again on the compacted chain
                    cell_ctrl.op = act_op;
                    count_next   = act_count;
                    removed_next = removed_reg + 1'b1;
                    state_next   = ST_EVAL;
                end
                else if (slot_free)
                begin
                    done                = 1'b1;
                    cell_ctrl.op        = act_op;
                    count_next          = act_count;
                    rsp_next.status     = act_status;
                    rsp_next.position   = act_position;
                    rsp_next.removed    = act_removed;
                    rsp_next.fill       = IDX_W'(act_count);
                    rsp_next.read_value = act_rd;
                    rsp_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        cell_pos = act_pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            removed_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            removed_reg   <= removed_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            op_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL)
        else $error("fill count above depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> state_reg == ST_EVAL)
        else $error("transfer did not start a compare pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> rsp_valid && rsp.fill == IDX_W'(count_reg))
        else $error("response fill does not match stored count");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status != STATUS_NOT_FOUND || rsp.removed == '0))
        else $error("not found reported with removed entries");

endmodule

// ===== tb/sv/tb_fixed_array_sorted_insert_delete.sv =====
// testbench for fixed_array_sorted_insert_delete: directed and random requests checked
// against a behavioral store model; random idling on both valid/stall channels
// depends on fasid_pkg and the fixed_array_sorted_insert_delete rtl
module tb_fixed_array_sorted_insert_delete;
    import fasid_pkg::*;

    localparam int DEPTH       = DEPTH_DEFAULT;
    localparam int RAND_ITEMS  = 1150;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 64;
    localparam int SHOW_MAX    = 10;

    // codes the block does not define, must report a bad index
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_7 = 3'd7;

    localparam logic [DATA_W-1:0] WORD_MAX = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;

    typedef struct packed {
        logic      drain;   // wait for every response before this transfer
        req_item_t item;
    } pending_req_t;

    typedef struct packed {
        req_item_t cause;
        rsp_item_t want;
    } expected_rsp_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_item_t req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp;

    pending_req_t  pending [$];
    expected_rsp_t expected_rsp [$];

    // model of the store
    logic signed [DATA_W-1:0] store [DEPTH];
    int unsigned              fill_cnt;

    int unsigned n_sent;
    int unsigned n_rsp;
    int unsigned idle_cycles;
    int unsigned idle_left;
    int unsigned stall_left;
    logic        tx_calm = 1'b0;
    logic        rx_calm = 1'b0;
    int unsigned n_bad = 0;
    int unsigned n_op [8];
    int unsigned n_full_hits = 0;
    int unsigned n_queued = 0;
    logic        next_drain = 1'b0;

    fixed_array_sorted_insert_delete #(
        .DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // mostly short, a few long
    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(15, 40);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2, 3:    return $urandom();
            // small pool so deletes find matches
            default: return DATA_W'(int'($urandom_range(0, 15)) - 8);
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        if ($urandom_range(0, 3) == 0)
            return IDX_W'($urandom_range(0, 31));
        return IDX_W'($urandom_range(0, DEPTH));
    endfunction

    task automatic add_req(logic [FUNC_W-1:0] f, logic [DATA_W-1:0] v, logic [IDX_W-1:0] i);
        pending_req_t p;
        p.drain      = next_drain;
        p.item.func  = f;
        p.item.value = v;
        p.item.index = i;
        pending.push_back(p);
        next_drain = 1'b0;
        n_queued++;
    endtask

    // shift entries up from pos and place v, dropping the last entry when full
    function automatic void shift_in(int unsigned pos, logic signed [DATA_W-1:0] v);
        int unsigned k;
        for (k = (fill_cnt < DEPTH) ? fill_cnt : DEPTH - 1; k > pos; k--)
            store[k] = store[k - 1];
        store[pos] = v;
        if (fill_cnt < DEPTH)
            fill_cnt++;
    endfunction

    function automatic rsp_item_t apply_op(req_item_t r);
        rsp_item_t                o;
        logic signed [DATA_W-1:0] v;
        int unsigned              k;
        int unsigned              w;
        int unsigned              nrem;
        o    = '0;
        v    = r.value;
        nrem = 0;
        case (r.func)
            FUNC_SORTED_INSERT:
            begin
                k = 0;
                while (k < fill_cnt && store[k] < v)
                    k++;
                // larger than everything in a full store: falls off the end
                if (k < DEPTH)
                    shift_in(k, v);
                o.position = IDX_W'(k);
            end
            FUNC_OVERWRITE:
            begin
                if (r.index < fill_cnt)
                begin
                    store[r.index] = v;
                    o.position     = r.index;
                end
                else
                    o.status = STATUS_BAD_INDEX;
            end
            FUNC_INSERT_AT:
            begin
                if (r.index <= fill_cnt && r.index < DEPTH)
                begin
                    shift_in(r.index, v);
                    o.position = r.index;
                end
                else
                    o.status = STATUS_BAD_INDEX;
            end
            FUNC_DELETE_FIRST:
            begin
                k = 0;
                while (k < fill_cnt && store[k] != v)
                    k++;
                if (k < fill_cnt)
                begin
                    for (w = k; w + 1 < fill_cnt; w++)
                        store[w] = store[w + 1];
                    fill_cnt--;
                    o.position = IDX_W'(k);
                    o.removed  = 1;
                end
                else
                    o.status = STATUS_NOT_FOUND;
            end
            FUNC_DELETE_ALL:
            begin
                w = 0;
                for (k = 0; k < fill_cnt; k++)
                begin
                    if (store[k] == v)
                        nrem++;
                    else
                    begin
                        store[w] = store[k];
                        w++;
                    end
                end
                fill_cnt  = w;
                o.removed = IDX_W'(nrem);
                if (nrem == 0)
                    o.status = STATUS_NOT_FOUND;
            end
            FUNC_READ:
            begin
                if (r.index < fill_cnt)
                begin
                    o.read_value = store[r.index];
                    o.position   = r.index;
                end
                else
                    o.status = STATUS_BAD_INDEX;
            end
            default:
                o.status = STATUS_BAD_INDEX;
        endcase
        o.fill = IDX_W'(fill_cnt);
        return o;
    endfunction

    // driver: feeds the request channel from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            idle_left <= 0;
            n_sent    <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                n_sent <= n_sent + 1;
            if (req_valid && req_stall)
            begin
                // stalled transfer holds its payload
            end
            else if (idle_left != 0)
            begin
                idle_left <= idle_left - 1;
                req_valid <= 1'b0;
            end
            else if (pending.size() != 0 &&
                     !(pending[0].drain && n_rsp != n_sent + (req_valid && !req_stall)))
            begin
                req       <= pending[0].item;
                req_valid <= 1'b1;
                pending.pop_front();
                if ($urandom_range(0, 63) == 0)
                    tx_calm <= !tx_calm;
                idle_left <= (tx_calm || $urandom_range(0, 1) == 0) ? 0 : pick_len();
            end
            else
                req_valid <= 1'b0;
        end
    end

    // monitor: predicts on request transfers, checks response transfers, drives stall
    always @(posedge clk or negedge rst_n)
    begin
        expected_rsp_t e;
        if (!rst_n)
        begin
            fill_cnt = 0;
            expected_rsp.delete();
            rsp_stall   <= 1'b0;
            stall_left  <= 0;
            n_rsp       <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                n_rsp <= n_rsp + 1;
                if (expected_rsp.size() == 0)
                begin
                    n_bad++;
                    if (n_bad <= SHOW_MAX)
                        $display("unexpected response: status %0d pos %0d fill %0d",
                                 rsp.status, rsp.position, rsp.fill);
                end
                else
                begin
                    e = expected_rsp.pop_front();
                    if (rsp.status !== e.want.status || rsp.position !== e.want.position ||
                        rsp.removed !== e.want.removed || rsp.fill !== e.want.fill ||
                        rsp.read_value !== e.want.read_value)
                    begin
                        n_bad++;
                        if (n_bad <= SHOW_MAX)
                            $display({"mismatch func %0d value %h index %0d: ",
                                      "want st %0d pos %0d rem %0d fill %0d rd %h, ",
                                      "got st %0d pos %0d rem %0d fill %0d rd %h"},
                                     e.cause.func, e.cause.value, e.cause.index,
                                     e.want.status, e.want.position, e.want.removed,
                                     e.want.fill, e.want.read_value,
                                     rsp.status, rsp.position, rsp.removed,
                                     rsp.fill, rsp.read_value);
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                n_op[req.func]++;
                if ((req.func == FUNC_SORTED_INSERT || req.func == FUNC_INSERT_AT) &&
                    fill_cnt == DEPTH)
                    n_full_hits++;
                e.cause = req;
                e.want  = apply_op(req);
                expected_rsp.push_back(e);
            end

            if ($urandom_range(0, 299) == 0)
                rx_calm <= !rx_calm;
            if (stall_left != 0)
            begin
                rsp_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                rsp_stall <= 1'b0;
                if (!rx_calm && $urandom_range(0, 3) == 0)
                    stall_left <= pick_len();
            end

            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(negedge clk);
        $display("watchdog: no transfer in %0d cycles", IDLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int unsigned kind;
        int unsigned len;
        int unsigned j;
        int unsigned k;
        int unsigned leftover;
        logic        first_seq;

        // directed: empty store, unused codes, extremes, index bounds
        add_req(FUNC_READ, '0, 0);
        add_req(FUNC_DELETE_FIRST, 5, 0);
        add_req(FUNC_DELETE_ALL, 5, 0);
        add_req(FUNC_INSERT_AT, 9, 1);
        add_req(FUNC_OVERWRITE, 9, 0);
        add_req(FUNC_UNUSED_6, '0, 0);
        add_req(FUNC_UNUSED_7, '1, 31);
        add_req(FUNC_SORTED_INSERT, WORD_MAX, 0);
        add_req(FUNC_SORTED_INSERT, WORD_MIN, 0);
        add_req(FUNC_SORTED_INSERT, 0, 0);
        add_req(FUNC_SORTED_INSERT, 0, 0);
        add_req(FUNC_INSERT_AT, '1, 0);
        add_req(FUNC_INSERT_AT, 3, 5);
        add_req(FUNC_INSERT_AT, 3, 7);
        add_req(FUNC_OVERWRITE, 32'haaaa_aaaa, 5);
        add_req(FUNC_OVERWRITE, 1, 6);
        add_req(FUNC_READ, '0, 5);
        add_req(FUNC_READ, '0, 31);
        add_req(FUNC_DELETE_FIRST, 0, 0);
        add_req(FUNC_DELETE_ALL, WORD_MAX, 0);
        add_req(FUNC_DELETE_ALL, 0, 0);
        add_req(FUNC_READ, '0, 0);
        add_req(FUNC_INSERT_AT, 1, IDX_W'(DEPTH));

        // random sequences; the first fills the store to test full behavior
        n_queued   = 0;
        first_seq  = 1'b1;
        next_drain = 1'b1;
        while (n_queued < RAND_ITEMS)
        begin
            kind = first_seq ? 0 : $urandom_range(0, 9);
            if (!first_seq && $urandom_range(0, 11) == 0)
                next_drain = 1'b1;
            case (kind)
                0, 1, 2:
                begin
                    len = $urandom_range(16, 22);
                    for (j = 0; j < len; j++)
                        add_req((first_seq || $urandom_range(0, 3) != 0) ?
                                FUNC_SORTED_INSERT : FUNC_INSERT_AT,
                                pick_value(), IDX_W'($urandom_range(0, DEPTH)));
                    add_req(FUNC_SORTED_INSERT, WORD_MAX, 0);
                    add_req(FUNC_SORTED_INSERT, WORD_MIN, 0);
                    add_req(FUNC_INSERT_AT, pick_value(), IDX_W'(DEPTH));
                    add_req(FUNC_INSERT_AT, pick_value(), IDX_W'(DEPTH - 1));
                    add_req(FUNC_READ, '0, pick_index());
                    add_req(FUNC_OVERWRITE, pick_value(), pick_index());
                end
                3, 4, 5:
                begin
                    len = $urandom_range(10, 30);
                    for (j = 0; j < len; j++)
                    begin
                        k = $urandom_range(0, 9);
                        add_req(k < 4 ? FUNC_DELETE_FIRST : k < 7 ? FUNC_DELETE_ALL :
                                k < 9 ? FUNC_READ : FUNC_SORTED_INSERT,
                                pick_value(), pick_index());
                    end
                end
                6, 7, 8:
                begin
                    len = $urandom_range(10, 40);
                    for (j = 0; j < len; j++)
                    begin
                        k = $urandom_range(0, 17);
                        add_req(k == 16 ? FUNC_UNUSED_6 : k == 17 ? FUNC_UNUSED_7 :
                                FUNC_W'(k % 6), pick_value(), pick_index());
                    end
                end
                default:
                begin
                    len = $urandom_range(4, 10);
                    for (j = 0; j < len; j++)
                        add_req(FUNC_W'($urandom_range(0, 7)), $urandom(),
                                IDX_W'($urandom_range(0, 31)));
                end
            endcase
            first_seq = 1'b0;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || req_valid || n_rsp != n_sent)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        leftover = expected_rsp.size();
        if (leftover != 0)
            $display("%0d responses never arrived", leftover);

        $display("ran %0d requests: sorted ins %0d, overwrite %0d, ins at %0d, del first %0d,",
                 n_sent, n_op[0], n_op[1], n_op[2], n_op[3]);
        $display("  del all %0d, read %0d, unused %0d; %0d inserts on a full store, %0d bad",
                 n_op[4], n_op[5], n_op[6] + n_op[7], n_full_hits, n_bad);
        if (n_bad == 0 && leftover == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
